@@ sv/pba_pkg.sv @@
// Package for the page bitmap allocator: sizes, result codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package pba_pkg;

    localparam int FRAME_W       = 36;
    localparam int POOL_PAGES    = 32768;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (POOL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int WORD_IDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WPTR_W        = $clog2(MAP_WORDS + 1);
    localparam int PAGE_W        = WORD_IDX_W + BIT_IDX_W;
    localparam int TDATA_W       = ((FRAME_W + 7) / 8) * 8;
    localparam int STATUS_W      = 2;

    // Frame 4096 is byte address 16 MiB with 4 KiB pages.
    localparam logic [FRAME_W-1:0] RESET_BASE = FRAME_W'(4096);

    typedef logic [MAP_WORD_BITS-1:0] word_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK      = 2'd0,
        RES_NO_MEM  = 2'd1,
        RES_INVALID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_CHK,
        ST_ALLOC_WR,
        ST_FREE_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        logic    hint_inc;
        logic    latch_bit;
        logic    wr_alloc;
        logic    wr_free;
        logic    set_res;
        status_t res_status;
        logic    push;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic pool_full;
        logic free_bad;
        logic free_untouched;
        logic word_full;
        logic idx_oob;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/pba_datapath.sv @@
// Datapath of the page bitmap allocator: bitmap memory, search hint,
// fill count, base register, frame arithmetic and the output register.
// Depends on pba_pkg.
`default_nettype none

module pba_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wen,
    input  wire logic [pba_pkg::FRAME_W-1:0]   cfg_wdata,
    input  wire logic                          in_opcode,
    input  wire logic [pba_pkg::FRAME_W-1:0]   in_frame,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [pba_pkg::FRAME_W-1:0]        out_frame,
    output pba_pkg::status_t                   out_status,
    input  wire pba_pkg::cmd_t                 cmd,
    output pba_pkg::stat_t                     stat
);

    pba_pkg::word_t                   mem [pba_pkg::MAP_WORDS];
    pba_pkg::word_t                   rdata_reg;

    logic [pba_pkg::FRAME_W-1:0]      base_reg;
    logic                             op_reg;
    logic [pba_pkg::FRAME_W-1:0]      frame_reg;
    logic [pba_pkg::WPTR_W-1:0]       hint_reg, hint_next;
    logic [pba_pkg::WPTR_W-1:0]       hwm_reg, hwm_next;
    logic [pba_pkg::BIT_IDX_W-1:0]    bit_reg;
    logic [pba_pkg::FRAME_W-1:0]      res_frame_reg;
    pba_pkg::status_t                 res_status_reg;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [pba_pkg::FRAME_W-1:0]      out_frame_reg;
    pba_pkg::status_t                 out_status_reg;

    logic [pba_pkg::FRAME_W-1:0]      diff;
    logic [pba_pkg::WORD_IDX_W-1:0]   free_word;
    logic [pba_pkg::BIT_IDX_W-1:0]    free_bit;
    logic [pba_pkg::WORD_IDX_W-1:0]   rd_addr;
    logic [pba_pkg::WORD_IDX_W-1:0]   wr_addr;
    pba_pkg::word_t                   cur_word;
    pba_pkg::word_t                   wdata;
    logic [pba_pkg::BIT_IDX_W-1:0]    low_zero;
    logic [pba_pkg::PAGE_W-1:0]       alloc_idx;

    // Free index is taken modulo 2^36, so a frame below the base wraps high.
    assign diff      = frame_reg - base_reg;
    assign free_word = diff[pba_pkg::BIT_IDX_W +: pba_pkg::WORD_IDX_W];
    assign free_bit  = diff[pba_pkg::BIT_IDX_W-1:0];
    assign rd_addr   = op_reg ? free_word : hint_reg[pba_pkg::WORD_IDX_W-1:0];
    assign wr_addr   = cmd.wr_free ? free_word : hint_reg[pba_pkg::WORD_IDX_W-1:0];
    assign alloc_idx = {hint_reg[pba_pkg::WORD_IDX_W-1:0], bit_reg};

    // Words at or above the fill count were never written and read as free.
    assign cur_word = (hint_reg >= hwm_reg) ? '0 : rdata_reg;

    always_comb begin
        low_zero = '0;
        for (int i = pba_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (!cur_word[i]) begin
                low_zero = pba_pkg::BIT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (cmd.wr_free) begin
            wdata = rdata_reg & ~(pba_pkg::word_t'(1) << free_bit);
        end else begin
            wdata = cur_word | (pba_pkg::word_t'(1) << bit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr_alloc || cmd.wr_free) begin
            mem[wr_addr] <= wdata;
        end
    end

    always_comb begin
        hint_next = hint_reg;
        hwm_next  = hwm_reg;
        if (cmd.hint_inc) begin
            hint_next = hint_reg + pba_pkg::WPTR_W'(1);
        end else if (cmd.wr_free) begin
            if (pba_pkg::WPTR_W'(free_word) < hint_reg) begin
                hint_next = pba_pkg::WPTR_W'(free_word);
            end
        end
        if (cmd.wr_alloc && (hint_reg == hwm_reg)) begin
            hwm_next = hwm_reg + pba_pkg::WPTR_W'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= pba_pkg::RESET_BASE;
            hint_reg     <= '0;
            hwm_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                base_reg <= cfg_wdata;
            end
            hint_reg     <= hint_next;
            hwm_reg      <= hwm_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= in_opcode;
            frame_reg <= in_frame;
        end
        if (cmd.latch_bit) begin
            bit_reg <= low_zero;
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_frame_reg  <= cmd.wr_alloc ?
                              base_reg + pba_pkg::FRAME_W'(alloc_idx) : '0;
        end
        if (cmd.push) begin
            out_frame_reg  <= res_frame_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.is_alloc       = !op_reg;
    assign stat.pool_full      = (hint_reg == pba_pkg::WPTR_W'(pba_pkg::MAP_WORDS));
    assign stat.free_bad       = (diff >= pba_pkg::FRAME_W'(pba_pkg::POOL_PAGES));
    assign stat.free_untouched = (pba_pkg::WPTR_W'(free_word) >= hwm_reg);
    assign stat.word_full      = &cur_word;
    assign stat.idx_oob        = (pba_pkg::FRAME_W'(alloc_idx)
                                  >= pba_pkg::FRAME_W'(pba_pkg::POOL_PAGES));
    assign stat.out_free       = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign out_frame  = out_frame_reg;
    assign out_status = out_status_reg;

`ifndef SYNTHESIS
    a_hint_below_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        hint_reg <= hwm_reg)
        else $error("search hint passed the fill count");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= pba_pkg::WPTR_W'(pba_pkg::MAP_WORDS))
        else $error("fill count beyond the bitmap");

    a_alloc_bit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_alloc |-> !cur_word[bit_reg])
        else $error("allocating a page that is already used");

    a_skip_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hint_inc |-> (&cur_word))
        else $error("search skipped a word with a free page");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> !$past(cmd.push))
        else $error("result overwritten while waiting");
`endif

endmodule

`default_nettype wire

@@ sv/pba_ctrl.sv @@
// Controller state machine of the page bitmap allocator: sequences the
// decode, bitmap read, search, update and response steps of each request.
// Depends on pba_pkg.
`default_nettype none

module pba_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pba_pkg::stat_t  stat,
    output pba_pkg::cmd_t        cmd
);

    pba_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pba_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = pba_pkg::RES_OK;
        s_tready       = 1'b0;
        unique case (state_reg)
            pba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = pba_pkg::ST_DECODE;
                end
            end
            pba_pkg::ST_DECODE: begin
                if (stat.is_alloc) begin
                    if (stat.pool_full) begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = pba_pkg::RES_NO_MEM;
                        state_next     = pba_pkg::ST_RESP;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        state_next = pba_pkg::ST_ALLOC_CHK;
                    end
                end else if (stat.free_bad) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = pba_pkg::RES_INVALID;
                    state_next     = pba_pkg::ST_RESP;
                end else if (stat.free_untouched) begin
                    // The page was never allocated, so its bit is already clear.
                    cmd.set_res = 1'b1;
                    state_next  = pba_pkg::ST_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = pba_pkg::ST_FREE_WR;
                end
            end
            pba_pkg::ST_ALLOC_CHK: begin
                if (stat.word_full) begin
                    cmd.hint_inc = 1'b1;
                    state_next   = pba_pkg::ST_DECODE;
                end else begin
                    cmd.latch_bit = 1'b1;
                    state_next    = pba_pkg::ST_ALLOC_WR;
                end
            end
            pba_pkg::ST_ALLOC_WR: begin
                cmd.set_res = 1'b1;
                if (stat.idx_oob) begin
                    cmd.res_status = pba_pkg::RES_NO_MEM;
                end else begin
                    cmd.wr_alloc = 1'b1;
                end
                state_next = pba_pkg::ST_RESP;
            end
            pba_pkg::ST_FREE_WR: begin
                cmd.wr_free = 1'b1;
                cmd.set_res = 1'b1;
                state_next  = pba_pkg::ST_RESP;
            end
            pba_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = pba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/page_bitmap_allocator_top.sv @@
// Top level of the page bitmap allocator: joins the controller and the
// datapath and maps the stream and configuration ports.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
`default_nettype none

// Channel   | Ports                         | Contents
// ----------+-------------------------------+-----------------------------------
// request   | s_tvalid s_tready s_tdata     | tdata: frame_in; tuser: opcode
//           | s_tuser                       |
// result    | m_tvalid m_tready m_tdata     | tdata: frame_out; tuser: status
//           | m_tuser                       |
// config    | cfg_wen cfg_wdata             | base_frame, written when cfg_wen
//
// One request is in work at a time; s_tready is high only while the
// controller is idle, and a request yields exactly one result transfer.
// A free passes decode with its bitmap read, write-back and response; an
// allocate passes decode with its read, check, write and response. Either goes
// from decode to the response for an invalid or untouched free page or a full
// pool. The search hint walks the single-port bitmap memory one word per read,
// back to decode for every full word, and points at the lowest word that may
// hold a free page, so the long walk only happens after a run of words filled
// up. Reset (aresetn low, synchronous) frees every page at once through a fill
// count: words at or above it were never written and read as all free, so
// there is no clearing pass. A stalled result waits in the output register;
// a later result waits in the response state until the stalled one is taken.
// The next request is accepted the cycle after the result transfer is loaded.
module page_bitmap_allocator_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration: base_frame.
    input  wire logic                          cfg_wen,
    input  wire logic [pba_pkg::FRAME_W-1:0]   cfg_wdata,
    // Request channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pba_pkg::TDATA_W-1:0]   s_tdata,  // [35:0] frame_in
    input  wire logic                          s_tuser,  // [0] opcode
    // Result channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pba_pkg::TDATA_W-1:0]        m_tdata,  // [35:0] frame_out
    output logic [pba_pkg::STATUS_W-1:0]       m_tuser   // [1:0] status
);

    pba_pkg::cmd_t                   cmd;
    pba_pkg::stat_t                  stat;
    logic [pba_pkg::FRAME_W-1:0]     out_frame;
    pba_pkg::status_t                out_status;

    pba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pba_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_opcode  (s_tuser),
        .in_frame   (s_tdata[pba_pkg::FRAME_W-1:0]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_frame  (out_frame),
        .out_status (out_status),
        .cmd        (cmd),
        .stat       (stat)
    );

    // The pad bits above the frame number are driven as zero.
    assign m_tdata = pba_pkg::TDATA_W'(out_frame);
    assign m_tuser = out_status;

endmodule

`default_nettype wire
